@@ src/spn_pkg.sv @@
// Package for the 16-bit SPN block cipher: S-box tables, bit permutation,
// round key selection and the per-cell control struct.
// No dependencies; used by spn_cell and spn_block_cipher_16bit.
`default_nettype none

package spn_pkg;

    // Cipher geometry.
    localparam int unsigned BLOCK_W    = 16;
    localparam int unsigned KEY_W      = 32;
    localparam int unsigned NUM_ROUNDS = 4;

    // Item direction codes.
    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    typedef logic [BLOCK_W-1:0] t_block;
    typedef logic [KEY_W-1:0]   t_key;
    typedef logic [3:0]         t_nibble;

    // Round keys and position flags that steer one cell.
    typedef struct packed {
        logic   first;
        logic   last;
        t_block pre_enc;
        t_block post_enc;
        t_block pre_dec;
        t_block post_dec;
    } t_cell_ctl;

    // Forward 4-bit S-box.
    function automatic t_nibble sbox_fwd(input t_nibble x);
        t_nibble y;
        case (x)
            4'h0: y = 4'd14;
            4'h1: y = 4'd4;
            4'h2: y = 4'd13;
            4'h3: y = 4'd1;
            4'h4: y = 4'd2;
            4'h5: y = 4'd15;
            4'h6: y = 4'd11;
            4'h7: y = 4'd8;
            4'h8: y = 4'd3;
            4'h9: y = 4'd10;
            4'ha: y = 4'd6;
            4'hb: y = 4'd12;
            4'hc: y = 4'd5;
            4'hd: y = 4'd9;
            4'he: y = 4'd0;
            4'hf: y = 4'd7;
            default: y = 4'd0;
        endcase
        return y;
    endfunction

    // Inverse 4-bit S-box.
    function automatic t_nibble sbox_inv(input t_nibble x);
        t_nibble y;
        case (x)
            4'h0: y = 4'd14;
            4'h1: y = 4'd3;
            4'h2: y = 4'd4;
            4'h3: y = 4'd8;
            4'h4: y = 4'd1;
            4'h5: y = 4'd12;
            4'h6: y = 4'd10;
            4'h7: y = 4'd15;
            4'h8: y = 4'd7;
            4'h9: y = 4'd13;
            4'ha: y = 4'd9;
            4'hb: y = 4'd6;
            4'hc: y = 4'd11;
            4'hd: y = 4'd2;
            4'he: y = 4'd0;
            4'hf: y = 4'd5;
            default: y = 4'd0;
        endcase
        return y;
    endfunction

    // Substitute all four nibbles, forward or inverse.
    function automatic t_block sub_word(input t_block x, input logic inv);
        t_block y;
        for (int n = 0; n < 4; n++) begin
            y[4*n +: 4] = inv ? sbox_inv(x[4*n +: 4]) : sbox_fwd(x[4*n +: 4]);
        end
        return y;
    endfunction

    // Bit transpose: counting from the MSB, bit 4a+b moves to bit 4b+a.
    // The permutation is its own inverse.
    function automatic t_block perm_word(input t_block x);
        t_block y;
        for (int a = 0; a < 4; a++) begin
            for (int b = 0; b < 4; b++) begin
                y[15 - (4*b + a)] = x[15 - (4*a + b)];
            end
        end
        return y;
    endfunction

    // Round key r (1..5): key nibbles r..r+3 counted from the top.
    function automatic t_block round_key(input t_key key, input int r);
        return t_block'(key >> (20 - 4*r));
    endfunction

endpackage

`default_nettype wire

@@ src/spn_block_cipher_16bit.sv @@
// Top level of the 16-bit four-round SPN block cipher: key register and a
// chain of four round cells. Depends on spn_pkg and spn_cell.
`default_nettype none

// The block encrypts (mode 0) or decrypts (mode 1) one 16-bit item with the
// 32-bit key written through i_cfg_we / i_cfg_wdata (reset value zero). It is
// a chain of four round cells, one per cipher round, each with its own stage
// register, so it takes one item per clock cycle unless output back-pressure
// fills the chain, and returns results in order. Each cell stalls only when
// it is full and its successor cannot take its item, so bubbles close up and
// the input stays ready while the output holds a result and earlier stages
// have room. Write the key only while no item is in flight.
module spn_block_cipher_16bit (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire spn_pkg::t_key   i_cfg_wdata,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic            i_mode,
    input  wire spn_pkg::t_block i_block_in,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output spn_pkg::t_block      o_block_out
);
    import spn_pkg::*;

    t_key r_cipher_key;

    logic   vld   [NUM_ROUNDS+1];
    logic   rdy   [NUM_ROUNDS+1];
    logic   mode  [NUM_ROUNDS+1];
    t_block data  [NUM_ROUNDS+1];

    // Key register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cipher_key <= '0;
        end else if (i_cfg_we) begin
            r_cipher_key <= i_cfg_wdata;
        end
    end

    // Chain ends.
    assign vld[0]      = i_in_valid;
    assign mode[0]     = i_mode;
    assign data[0]     = i_block_in;
    assign o_in_ready  = rdy[0];
    assign rdy[NUM_ROUNDS] = i_out_ready;
    assign o_out_valid = vld[NUM_ROUNDS];
    assign o_block_out = data[NUM_ROUNDS];

    // Round cells. Cell j runs encryption round j+1 or inverts encryption round 4-j.
    for (genvar j = 0; j < NUM_ROUNDS; j++) begin : g_cell
        t_cell_ctl ctl;

        always_comb begin
            ctl.first    = (j == 0);
            ctl.last     = (j == NUM_ROUNDS - 1);
            ctl.pre_enc  = round_key(r_cipher_key, j + 1);
            ctl.post_enc = round_key(r_cipher_key, NUM_ROUNDS + 1);
            ctl.pre_dec  = round_key(r_cipher_key, NUM_ROUNDS + 1);
            ctl.post_dec = round_key(r_cipher_key, NUM_ROUNDS - j);
        end

        spn_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (vld[j]),
            .o_ready (rdy[j]),
            .i_mode  (mode[j]),
            .i_data  (data[j]),
            .i_ctl   (ctl),
            .o_valid (vld[j+1]),
            .i_ready (rdy[j+1]),
            .o_mode  (mode[j+1]),
            .o_data  (data[j+1])
        );
    end

    // The input only stalls when a finished result is waiting.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("spn_block_cipher_16bit: input stalled with output free");

    // With the output ready, an accepted item passes every stage register and comes out.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready
        |=> o_out_valid)
        else $error("spn_block_cipher_16bit: result missing after four cycles");

    // A result that is taken is replaced only by a result further back.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !vld[NUM_ROUNDS-1] |=> !o_out_valid)
        else $error("spn_block_cipher_16bit: result repeated");

endmodule

`default_nettype wire

@@ src/spn_cell.sv @@
// One round cell of the SPN cipher pipeline: key mix, S-box layer and
// permutation for either direction, with its own valid/ready stage register.
// Depends on spn_pkg.
`default_nettype none

module spn_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_mode,
    input  wire spn_pkg::t_block    i_data,
    input  wire spn_pkg::t_cell_ctl i_ctl,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic                    o_mode,
    output spn_pkg::t_block         o_data
);
    import spn_pkg::*;

    logic   r_vld;
    logic   r_mode;
    t_block r_data;
    t_block n_data;
    t_block pre;
    t_block sub;

    // The stage can take an item when it is empty or its item moves on.
    assign o_ready = !r_vld || i_ready;

    // Round function. Decryption runs the inverse steps in reverse order.
    always_comb begin
        if (i_mode == MODE_DECRYPT) begin
            pre = i_ctl.first ? (i_data ^ i_ctl.pre_dec) : perm_word(i_data);
        end else begin
            pre = i_data ^ i_ctl.pre_enc;
        end
        sub = sub_word(pre, i_mode == MODE_DECRYPT);
        if (i_mode == MODE_DECRYPT) begin
            n_data = sub ^ i_ctl.post_dec;
        end else begin
            n_data = i_ctl.last ? (sub ^ i_ctl.post_enc) : perm_word(sub);
        end
    end

    // Stage valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mode <= i_mode;
            r_data <= n_data;
        end
    end

    assign o_valid = r_vld;
    assign o_mode  = r_mode;
    assign o_data  = r_data;

    // An item taken in always lands in the stage.
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_vld)
        else $error("spn_cell: accepted item was lost");

    // A held item keeps its value while downstream stalls.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !i_ready |=> r_vld && $stable(r_data) && $stable(r_mode))
        else $error("spn_cell: stalled item changed");

    // An empty stage never refuses an item.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld |-> o_ready)
        else $error("spn_cell: empty stage not ready");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking testbench for the 16-bit four-round SPN block cipher.
// Depends on spn_pkg and spn_block_cipher_16bit; the scoreboard class below
// predicts every encrypt and decrypt result from the current key.
`timescale 1ns / 1ps

module tb;

    localparam int PIPE_DEPTH     = 4;
    localparam int SETTLE_CYCLES  = PIPE_DEPTH + 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;
    localparam int NUM_PHASES     = 7;
    localparam int PHASE_ITEMS    = 270;

    // Scoreboard: a bit-exact cipher predictor plus the queue of blocks still
    // owed by the design, in acceptance order.
    class cipher_scoreboard;
        typedef struct {
            logic            mode;
            spn_pkg::t_block block_in;
            spn_pkg::t_block block_out;
        } t_owed;

        bit [3:0] fwd_sub[16] = '{14, 4, 13, 1, 2, 15, 11, 8, 3, 10, 6, 12, 5, 9, 0, 7};
        bit [3:0] inv_sub[16] = '{14, 3, 4, 8, 1, 12, 10, 15, 7, 13, 9, 6, 11, 2, 0, 5};
        bit [3:0] bit_dest[16] = '{0, 4, 8, 12, 1, 5, 9, 13, 2, 6, 10, 14, 3, 7, 11, 15};

        spn_pkg::t_key   key;
        spn_pkg::t_block rkeys[1:5];
        t_owed           owed_blocks[$];
        int              n_errors;
        int              n_checked;
        int              n_enc;
        int              n_dec;

        function new();
            n_errors  = 0;
            n_checked = 0;
            n_enc     = 0;
            n_dec     = 0;
            set_key('0);
        endfunction

        // Round key r is the 16-bit window that starts at key nibble r.
        function void set_key(spn_pkg::t_key k);
            key = k;
            for (int r = 1; r <= 5; r++) begin
                rkeys[r] = k[(35 - 4*r) -: 16];
            end
        endfunction

        function spn_pkg::t_block substitute(spn_pkg::t_block x, bit inv);
            spn_pkg::t_block y;
            for (int n = 0; n < 4; n++) begin
                y[4*n +: 4] = inv ? inv_sub[x[4*n +: 4]] : fwd_sub[x[4*n +: 4]];
            end
            return y;
        endfunction

        // Bit positions count from the MSB; bit i lands on bit_dest[i].
        function spn_pkg::t_block permute(spn_pkg::t_block x);
            spn_pkg::t_block y;
            for (int i = 0; i < 16; i++) begin
                y[15 - bit_dest[i]] = x[15 - i];
            end
            return y;
        endfunction

        function spn_pkg::t_block encrypt_block(spn_pkg::t_block x);
            for (int r = 1; r <= 3; r++) begin
                x = permute(substitute(x ^ rkeys[r], 1'b0));
            end
            x = substitute(x ^ rkeys[4], 1'b0);
            return x ^ rkeys[5];
        endfunction

        function spn_pkg::t_block decrypt_block(spn_pkg::t_block x);
            x = substitute(x ^ rkeys[5], 1'b1) ^ rkeys[4];
            for (int r = 3; r >= 1; r--) begin
                x = substitute(permute(x), 1'b1) ^ rkeys[r];
            end
            return x;
        endfunction

        // An accepted input item: work out the block the design owes for it.
        function void note_input(logic mode, spn_pkg::t_block blk);
            t_owed e;
            e.mode     = mode;
            e.block_in = blk;
            if (mode == spn_pkg::MODE_DECRYPT) begin
                e.block_out = decrypt_block(blk);
                n_dec++;
            end else begin
                e.block_out = encrypt_block(blk);
                n_enc++;
            end
            owed_blocks.push_back(e);
        endfunction

        function void report(string what, t_owed e, spn_pkg::t_block got);
            n_errors++;
            if (n_errors <= REPORT_LIMIT) begin
                $display("[%0t] %s: mode %0d in %04h key %08h expected %04h got %04h",
                         $realtime, what, e.mode, e.block_in, key, e.block_out, got);
            end
        endfunction

        // An accepted result item: compare with the oldest owed block.
        function void check_result(spn_pkg::t_block got);
            t_owed e;
            n_checked++;
            if (owed_blocks.size() == 0) begin
                e.mode      = 1'bx;
                e.block_in  = 'x;
                e.block_out = 'x;
                report("unexpected result", e, got);
            end else begin
                e = owed_blocks.pop_front();
                if (got !== e.block_out) begin
                    report("mismatch", e, got);
                end
            end
        endfunction

        function int pending();
            return owed_blocks.size();
        endfunction
    endclass

    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            i_cfg_we    = 1'b0;
    spn_pkg::t_key   i_cfg_wdata = '0;
    logic            i_in_valid  = 1'b0;
    logic            i_mode      = spn_pkg::MODE_ENCRYPT;
    spn_pkg::t_block i_block_in  = '0;
    logic            i_out_ready = 1'b0;
    logic            o_in_ready;
    logic            o_out_valid;
    spn_pkg::t_block o_block_out;

    cipher_scoreboard sb = new();
    bit               idle_en = 1'b1;
    int               stall_cycles = 0;
    int               n_keys = 1;

    spn_block_cipher_16bit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_block_in  (i_block_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_block_out (o_block_out)
    );

    always #1 i_clk = ~i_clk;

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_en || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    // Random block, with a bias toward all-zero, all-one, one-hot and one-cold values.
    function automatic spn_pkg::t_block pick_block();
        int              r;
        spn_pkg::t_block hot;
        r   = $urandom_range(0, 99);
        hot = spn_pkg::t_block'(1) << $urandom_range(0, 15);
        if (r < 3) begin
            return '0;
        end else if (r < 6) begin
            return '1;
        end else if (r < 9) begin
            return hot;
        end else if (r < 12) begin
            return ~hot;
        end
        return spn_pkg::t_block'($urandom_range(0, 65535));
    endfunction

    // Present one item and hold it until it is taken. Valid stays high across
    // back-to-back items and is only dropped when a gap is inserted.
    task automatic send_item(input logic mode, input spn_pkg::t_block blk);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_block_in <= blk;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        sb.note_input(mode, blk);
    endtask

    // Drain the pipeline, then load a new key while nothing is in flight.
    task automatic load_key(input spn_pkg::t_key k);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= k;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_key(k);
        n_keys++;
    endtask

    // Output side: random stalls between stretches of readiness.
    initial begin : out_ready_gen
        int n;
        forever begin
            n = pick_gap();
            if (n > 0) begin
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_block_out);
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles, %0d results still owed",
                     stall_cycles, sb.pending());
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        spn_pkg::t_block corner_blocks[11];
        spn_pkg::t_key   phase_keys[NUM_PHASES];
        bit              phase_idle[NUM_PHASES];

        corner_blocks = '{
            16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'hAAAA, 16'h5555,
            16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0, 16'h1234
        };
        phase_idle = '{1, 0, 1, 1, 0, 1, 1};

        phase_keys[0] = 32'hFFFF_FFFF;
        phase_keys[1] = 32'h0000_0000;
        phase_keys[2] = 32'h8000_0001;
        phase_keys[3] = spn_pkg::t_key'($urandom);
        phase_keys[4] = spn_pkg::t_key'($urandom);
        phase_keys[5] = 32'h7FFF_FFFE;
        phase_keys[6] = spn_pkg::t_key'($urandom);

        // Synchronous reset, then release.
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Corner blocks in both directions under the reset key of zero.
        foreach (corner_blocks[i]) begin
            send_item(spn_pkg::MODE_ENCRYPT, corner_blocks[i]);
            send_item(spn_pkg::MODE_DECRYPT, corner_blocks[i]);
        end

        // Random blocks under a series of keys, some phases without idling.
        for (int p = 0; p < NUM_PHASES; p++) begin
            load_key(phase_keys[p]);
            idle_en = phase_idle[p];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_item($urandom_range(0, 1) ? spn_pkg::MODE_DECRYPT
                                               : spn_pkg::MODE_ENCRYPT,
                          pick_block());
            end
            i_in_valid <= 1'b0;
        end

        // Wait for the last results, then let the pipeline go quiet.
        idle_en = 1'b1;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (sb.pending() != 0) begin
            $display("%0d expected results never arrived", sb.pending());
            sb.n_errors++;
        end
        $display("Run covered %0d encrypt and %0d decrypt items over %0d keys;",
                 sb.n_enc, sb.n_dec, n_keys);
        $display("%0d results checked, %0d errors.", sb.n_checked, sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/spn_pkg.sv
src/spn_cell.sv
src/spn_block_cipher_16bit.sv
bench/tb.sv
